// ===== design/assert_macros.svh =====
// Assertion macros used by the scheduler datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent must be followed in the same cycle by the consequent
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CHK_ALWAYS(label, clk, rst_n, prop, msg)
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ptrs_pkg.sv =====
// Shared codes and controller/datapath interface types for the task scheduler
`default_nettype none
package ptrs_pkg;

    localparam logic [1:0] KIND_ADD_OK  = 2'd0;
    localparam logic [1:0] KIND_ADD_REJ = 2'd1;
    localparam logic [1:0] KIND_DUE     = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam int MAX_RESULTS = 16;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic tick_start;
        logic add_exec;
        logic rd_issue;
        logic eval_latch;
        logic commit;
        logic advance;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic table_empty;
        logic hit;
        logic more;
        logic pend_blocked;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/periodic_task_release_scheduler_top.sv =====
// Top level of the periodic task release scheduler
//
// Input channel (item_valid/item_ready): one word per command. cmd 0 adds a
// task with the given period and priority_req; cmd 1 advances the tick
// counter by one and dispatches each task whose release time has come, at
// most MAX_RESULTS per tick. Output channel (result_valid/result_ready):
// words of kind, task_slot, tick_now and last; last marks the final word
// caused by one command. An add's word moves from the pending register to
// the output register in the closing step, once the output is free. A tick
// walks every priority level and, within it, every used slot through one
// read port of the task table: a read and an evaluation step per slot per
// level, an update step per due task and a closing step. Due words leave
// one step behind the scan, so the last one can be flagged.
// A new command is taken only once the previous one has finished; the
// output register frees the scan from waiting on the receiver, but a stalled
// receiver holds the scan at the next due task until its word is taken.
// Reset clears the tick counter and empties the table; table contents are
// not cleared, since only slots that have been added are ever read.
`default_nettype none
module periodic_task_release_scheduler_top
    import ptrs_pkg::*;
#(
    parameter int TASK_SLOTS   = 16,
    parameter int LOWEST_LEVEL = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        cmd,
    input  wire logic [31:0] period,
    input  wire logic [7:0]  priority_req,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       kind,
    output logic [3:0]       task_slot,
    output logic [31:0]      tick_now,
    output logic             last
);

    ctrl_cmd_t  cmds;
    dp_status_t status;

    // sequence adds, scan steps and the closing word
    ptrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status),
        .cmds       (cmds)
    );

    // hold the table, the tick counter and the output word
    ptrs_datapath #(
        .TASK_SLOTS   (TASK_SLOTS),
        .LOWEST_LEVEL (LOWEST_LEVEL)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .period       (period),
        .priority_req (priority_req),
        .cmds         (cmds),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .task_slot    (task_slot),
        .tick_now     (tick_now),
        .last         (last)
    );

endmodule
`default_nettype wire

// ===== design/ptrs_ctrl.sv =====
// Sequencing state machine for the task scheduler
`default_nettype none
module ptrs_ctrl
    import ptrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic       cmd,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmds
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmds       = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (cmd)
                    begin
                        cmds.tick_start = 1'b1;
                        state_next      = status.table_empty ? ST_DONE : ST_READ;
                    end
                    else
                    begin
                        cmds.add_exec = 1'b1;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                cmds.rd_issue = 1'b1;
                state_next    = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.hit)
                begin
                    cmds.eval_latch = 1'b1;
                    state_next      = ST_UPD;
                end
                else
                begin
                    cmds.advance = 1'b1;
                    state_next   = status.more ? ST_READ : ST_DONE;
                end
            end
            ST_UPD:
            begin
                // hold until the previous due word can move to the output
                if (!status.pend_blocked)
                begin
                    cmds.commit  = 1'b1;
                    cmds.advance = 1'b1;
                    state_next   = status.more ? ST_READ : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmds.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/ptrs_datapath.sv =====
// Task table memory, tick counter, scan pointers and output register
`default_nettype none
`include "assert_macros.svh"
module ptrs_datapath
    import ptrs_pkg::*;
#(
    parameter int TASK_SLOTS   = 16,
    parameter int LOWEST_LEVEL = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] period,
    input  wire logic [7:0]  priority_req,
    input  wire ctrl_cmd_t   cmds,
    output dp_status_t       status,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       kind,
    output logic [3:0]       task_slot,
    output logic [31:0]      tick_now,
    output logic             last
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW = (LOWEST_LEVEL > 0) ? $clog2(LOWEST_LEVEL + 1) : 1;
    localparam int MW = LW + 64;

    // word layout: level | period | release
    logic [MW-1:0] slot_mem [TASK_SLOTS];
    logic [MW-1:0] rd_word_reg;

    logic [31:0]   tick_reg;
    logic [SW:0]   total_reg;
    logic [SW-1:0] slot_reg;
    logic [LW-1:0] lvl_reg;
    logic [NW-1:0] n_reg;
    logic [31:0]   new_rel_reg;
    logic          pend_valid_reg;
    logic [1:0]    pend_kind_reg;
    logic [SW-1:0] pend_slot_reg;

    logic          result_valid_reg;
    logic [1:0]    kind_reg;
    logic [SW-1:0] slot_out_reg;
    logic [31:0]   tick_now_reg;
    logic          last_reg;

    logic [LW-1:0] rd_level;
    logic [31:0]   rd_period;
    logic [31:0]   rd_release;
    logic [31:0]   due_diff;
    logic [31:0]   rel_diff;
    logic [31:0]   rel_fix;
    logic [31:0]   rel_write;
    logic [LW-1:0] prio_clamped;
    logic          add_ok;
    logic [SW:0]   slot_inc;
    logic          more_slots;
    logic          more_levels;
    logic          out_free;
    logic          load_mid;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [SW+3:0] slot_wide;

    assign rd_level   = rd_word_reg[MW-1:64];
    assign rd_period  = rd_word_reg[63:32];
    assign rd_release = rd_word_reg[31:0];

    assign due_diff  = tick_reg - rd_release;
    assign rel_diff  = tick_reg - new_rel_reg;
    assign rel_fix   = tick_reg + rd_period;
    // still overdue after one period: reschedule from now
    assign rel_write = rel_diff[31] ? new_rel_reg : rel_fix;

    assign prio_clamped = (priority_req > 8'(LOWEST_LEVEL)) ? LW'(LOWEST_LEVEL)
                                                           : priority_req[LW-1:0];
    assign add_ok = (total_reg != (SW+1)'(TASK_SLOTS)) && (period != 32'd0);

    assign slot_inc    = {1'b0, slot_reg} + 1'b1;
    assign more_slots  = slot_inc < total_reg;
    assign more_levels = lvl_reg != LW'(LOWEST_LEVEL);

    assign out_free = !result_valid_reg || result_ready;
    assign load_mid = cmds.commit && pend_valid_reg;

    always_comb
    begin
        status.table_empty  = (total_reg == '0);
        status.hit          = (rd_level == lvl_reg) && !due_diff[31]
                              && (n_reg < NW'(MAX_RESULTS));
        status.more         = more_slots || more_levels;
        status.pend_blocked = pend_valid_reg && !out_free;
        status.out_free     = out_free;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {rd_level, rd_period, rel_write};
        if (cmds.add_exec && add_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = total_reg[SW-1:0];
            mem_wdata = {prio_clamped, period, tick_reg + period};
        end
        else if (cmds.commit)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmds.rd_issue)
        begin
            rd_word_reg <= slot_mem[slot_reg];
        end
        if (cmds.eval_latch)
        begin
            new_rel_reg <= rd_release + rd_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            total_reg      <= '0;
            slot_reg       <= '0;
            lvl_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= KIND_NONE;
            pend_slot_reg  <= '0;
        end
        else
        begin
            if (cmds.tick_start)
            begin
                tick_reg       <= tick_reg + 32'd1;
                slot_reg       <= '0;
                lvl_reg        <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmds.add_exec)
            begin
                pend_valid_reg <= 1'b1;
                if (add_ok)
                begin
                    pend_kind_reg <= KIND_ADD_OK;
                    pend_slot_reg <= total_reg[SW-1:0];
                    total_reg     <= total_reg + 1'b1;
                end
                else
                begin
                    pend_kind_reg <= KIND_ADD_REJ;
                    pend_slot_reg <= '0;
                end
            end
            if (cmds.commit)
            begin
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= KIND_DUE;
                pend_slot_reg  <= slot_reg;
                n_reg          <= n_reg + 1'b1;
            end
            if (cmds.advance)
            begin
                if (more_slots)
                begin
                    slot_reg <= slot_inc[SW-1:0];
                end
                else
                begin
                    slot_reg <= '0;
                    lvl_reg  <= lvl_reg + 1'b1;
                end
            end
            if (cmds.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_mid || cmds.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_mid)
        begin
            kind_reg     <= pend_kind_reg;
            slot_out_reg <= pend_slot_reg;
            tick_now_reg <= tick_reg;
            last_reg     <= 1'b0;
        end
        else if (cmds.finish)
        begin
            kind_reg     <= pend_valid_reg ? pend_kind_reg : KIND_NONE;
            slot_out_reg <= pend_valid_reg ? pend_slot_reg : '0;
            tick_now_reg <= tick_reg;
            last_reg     <= 1'b1;
        end
    end

    assign slot_wide    = {4'b0000, slot_out_reg};
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign task_slot    = slot_wide[3:0];
    assign tick_now     = tick_now_reg;
    assign last         = last_reg;

    `CHK_ALWAYS(a_total_bound, clk, rst_n, total_reg <= (SW+1)'(TASK_SLOTS), "table count overflow")
    `CHK_ALWAYS(a_count_bound, clk, rst_n, n_reg <= NW'(MAX_RESULTS), "result count overflow")
    `CHK_IMPLY(a_no_overwrite, clk, rst_n, (load_mid || cmds.finish) && result_valid_reg, result_ready, "output word overwritten")
    `CHK_IMPLY(a_commit_hit, clk, rst_n, cmds.commit, n_reg < NW'(MAX_RESULTS), "due word beyond result limit")

endmodule
`default_nettype wire
